FILE: rtl/wcrl_pkg.sv
// Shared types and constants for the wheel command ratio limiter.
// No dependencies; every other file of the block imports this package.
package wcrl_pkg;

    localparam int WHEELS                 = 4;
    localparam int CMD_W                  = 15;
    localparam int GAIN_W                 = 16;
    localparam int OUT_W                  = 16;
    localparam int RPM_FRACTION_BITS      = 4;
    localparam int RPM_WIDTH_DEF          = 24;
    localparam int GAIN_FRACTION_BITS_DEF = 8;
    localparam int ADDR_W                 = 4;

    localparam logic [CMD_W-1:0]  MAX_COMMAND_RST   = 15'd32767;
    localparam logic [GAIN_W-1:0] UNITS_PER_RPM_RST = 16'd2560;
    localparam logic [WHEELS-1:0] DIRECTION_RST     = 4'd0;

    typedef enum logic [1:0] {
        REG_MAX_COMMAND   = 2'd0,
        REG_UNITS_PER_RPM = 2'd1,
        REG_DIRECTION     = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [CMD_W-1:0]  max_command;
        logic [GAIN_W-1:0] units_per_rpm;
        logic [WHEELS-1:0] direction_flags;
    } cfg_t;

endpackage

FILE: rtl/wcrl_front.sv
// Front stages: magnitude and sign, gain multiply, largest magnitude, numerator.
// Depends on wcrl_pkg.
module wcrl_front import wcrl_pkg::*; #(
    parameter int RPM_W  = RPM_WIDTH_DEF,
    parameter int FRAC_W = RPM_FRACTION_BITS + GAIN_FRACTION_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cfg_t                         cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [RPM_W-1:0]             in_rpm    [WHEELS],
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [RPM_W+GAIN_W+CMD_W-1:0] out_num  [WHEELS],
    output logic [RPM_W+GAIN_W-1:0]      out_den,
    output logic [RPM_W+GAIN_W-1:0]      out_mag   [WHEELS],
    output logic                         out_bypass,
    output logic [WHEELS-1:0]            out_neg
);

    localparam int MAG_W = RPM_W + GAIN_W;
    localparam int N_W   = MAG_W + CMD_W;
    localparam int QW    = CMD_W + FRAC_W;
    localparam int CMP_W = (MAG_W > QW) ? MAG_W : QW;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;
    logic [RPM_W-1:0]  abs1_reg [WHEELS];
    logic [MAG_W-1:0]  mag2_reg [WHEELS];
    logic [MAG_W-1:0]  mag3_reg [WHEELS];
    logic [MAG_W-1:0]  mag4_reg [WHEELS];
    logic [MAG_W-1:0]  largest3_reg, den4_reg;
    logic [N_W-1:0]    num4_reg [WHEELS];
    logic [WHEELS-1:0] neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic              bypass4_reg;
    logic [MAG_W-1:0]  max01, max23;
    logic [QW-1:0]     limit_q;

    assign adv4     = !v4_reg || out_ready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    assign max01   = (mag2_reg[0] > mag2_reg[1]) ? mag2_reg[0] : mag2_reg[1];
    assign max23   = (mag2_reg[2] > mag2_reg[3]) ? mag2_reg[2] : mag2_reg[3];
    assign limit_q = {cfg.max_command, {FRAC_W{1'b0}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        // magnitude; the most negative value maps to 2^(RPM_W-1) unsigned
        if (adv1 && in_valid) begin
            for (int w = 0; w < WHEELS; w++) begin
                abs1_reg[w] <= in_rpm[w][RPM_W-1] ? (~in_rpm[w] + 1'b1) : in_rpm[w];
                neg1_reg[w] <= in_rpm[w][RPM_W-1] ^ cfg.direction_flags[w];
            end
        end
        if (adv2 && v1_reg) begin
            for (int w = 0; w < WHEELS; w++) begin
                mag2_reg[w] <= MAG_W'(abs1_reg[w]) * MAG_W'(cfg.units_per_rpm);
            end
            neg2_reg <= neg1_reg;
        end
        if (adv3 && v2_reg) begin
            largest3_reg <= (max01 > max23) ? max01 : max23;
            mag3_reg     <= mag2_reg;
            neg3_reg     <= neg2_reg;
        end
        if (adv4 && v3_reg) begin
            for (int w = 0; w < WHEELS; w++) begin
                num4_reg[w] <= N_W'(mag3_reg[w]) * N_W'(cfg.max_command);
            end
            den4_reg    <= largest3_reg;
            bypass4_reg <= !(CMP_W'(largest3_reg) > CMP_W'(limit_q));
            mag4_reg    <= mag3_reg;
            neg4_reg    <= neg3_reg;
        end
    end

    assign out_valid  = v4_reg;
    assign out_num    = num4_reg;
    assign out_den    = den4_reg;
    assign out_mag    = mag4_reg;
    assign out_bypass = bypass4_reg;
    assign out_neg    = neg4_reg;

endmodule

FILE: rtl/wcrl_divider.sv
// Pipelined restoring divider, one quotient bit per stage, four wheels in lanes.
// Depends on wcrl_pkg.
module wcrl_divider import wcrl_pkg::*; #(
    parameter int MAG_W  = RPM_WIDTH_DEF + GAIN_W,
    parameter int FRAC_W = RPM_FRACTION_BITS + GAIN_FRACTION_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [MAG_W+CMD_W-1:0]    in_num  [WHEELS],
    input  logic [MAG_W-1:0]          in_den,
    input  logic [MAG_W-1:0]          in_mag  [WHEELS],
    input  logic                      in_bypass,
    input  logic [WHEELS-1:0]         in_neg,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [CMD_W+FRAC_W-1:0]   out_quo [WHEELS],
    output logic [MAG_W-1:0]          out_mag [WHEELS],
    output logic                      out_bypass,
    output logic [WHEELS-1:0]         out_neg
);

    localparam int QW = CMD_W + FRAC_W;

    logic [QW:1]       valid_reg;
    logic [QW+1:1]     adv;
    logic [MAG_W-1:0]  rem_reg [1:QW][WHEELS];
    logic [QW-1:0]     low_reg [1:QW][WHEELS];
    logic [QW-1:0]     quo_reg [1:QW][WHEELS];
    logic [MAG_W-1:0]  mag_reg [1:QW][WHEELS];
    logic [MAG_W-1:0]  den_reg [1:QW];
    logic [QW:1]       bypass_reg;
    logic [WHEELS-1:0] neg_reg [1:QW];

    logic              p_valid  [1:QW];
    logic [MAG_W-1:0]  p_rem    [1:QW][WHEELS];
    logic [QW-1:0]     p_low    [1:QW][WHEELS];
    logic [QW-1:0]     p_quo    [1:QW][WHEELS];
    logic [MAG_W-1:0]  p_mag    [1:QW][WHEELS];
    logic [MAG_W-1:0]  p_den    [1:QW];
    logic              p_bypass [1:QW];
    logic [WHEELS-1:0] p_neg    [1:QW];
    logic [MAG_W:0]    trial    [1:QW][WHEELS];
    logic [MAG_W:0]    diff     [1:QW][WHEELS];
    logic              fits     [1:QW][WHEELS];

    assign adv[QW+1] = out_ready;
    assign in_ready  = adv[1];

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        assign adv[k] = !valid_reg[k] || adv[k+1];

        if (k == 1) begin : g_first
            // remainder starts with the numerator's top bits; the rest feed in one a stage
            assign p_valid[k]  = in_valid;
            assign p_den[k]    = in_den;
            assign p_bypass[k] = in_bypass;
            assign p_neg[k]    = in_neg;
            for (genvar w = 0; w < WHEELS; w++) begin : g_lane
                assign p_rem[k][w] = in_num[w][MAG_W+CMD_W-1:CMD_W];
                assign p_low[k][w] = {in_num[w][CMD_W-1:0], {FRAC_W{1'b0}}};
                assign p_quo[k][w] = '0;
                assign p_mag[k][w] = in_mag[w];
            end
        end else begin : g_next
            assign p_valid[k]  = valid_reg[k-1];
            assign p_den[k]    = den_reg[k-1];
            assign p_bypass[k] = bypass_reg[k-1];
            assign p_neg[k]    = neg_reg[k-1];
            for (genvar w = 0; w < WHEELS; w++) begin : g_lane
                assign p_rem[k][w] = rem_reg[k-1][w];
                assign p_low[k][w] = low_reg[k-1][w];
                assign p_quo[k][w] = quo_reg[k-1][w];
                assign p_mag[k][w] = mag_reg[k-1][w];
            end
        end

        for (genvar w = 0; w < WHEELS; w++) begin : g_cmp
            assign trial[k][w] = {p_rem[k][w], p_low[k][w][QW-1]};
            assign diff[k][w]  = trial[k][w] - {1'b0, p_den[k]};
            assign fits[k][w]  = trial[k][w] >= {1'b0, p_den[k]};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (adv[k]) begin
                valid_reg[k] <= p_valid[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[k] && p_valid[k]) begin
                for (int w = 0; w < WHEELS; w++) begin
                    rem_reg[k][w] <= fits[k][w] ? diff[k][w][MAG_W-1:0]
                                                : trial[k][w][MAG_W-1:0];
                    quo_reg[k][w] <= {p_quo[k][w][QW-2:0], fits[k][w]};
                    low_reg[k][w] <= {p_low[k][w][QW-2:0], 1'b0};
                    mag_reg[k][w] <= p_mag[k][w];
                end
                den_reg[k]    <= p_den[k];
                bypass_reg[k] <= p_bypass[k];
                neg_reg[k]    <= p_neg[k];
            end
        end
    end

    assign out_valid  = valid_reg[QW];
    assign out_quo    = quo_reg[QW];
    assign out_mag    = mag_reg[QW];
    assign out_bypass = bypass_reg[QW];
    assign out_neg    = neg_reg[QW];

endmodule

FILE: rtl/wcrl_round.sv
// Back stages: select scaled or raw magnitude, clamp, round half away, apply sign.
// Depends on wcrl_pkg.
module wcrl_round import wcrl_pkg::*; #(
    parameter int MAG_W  = RPM_WIDTH_DEF + GAIN_W,
    parameter int FRAC_W = RPM_FRACTION_BITS + GAIN_FRACTION_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cfg_t                    cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [CMD_W+FRAC_W-1:0] in_quo [WHEELS],
    input  logic [MAG_W-1:0]        in_mag [WHEELS],
    input  logic                    in_bypass,
    input  logic [WHEELS-1:0]       in_neg,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [OUT_W-1:0]        out_cmd [WHEELS]
);

    localparam int QW    = CMD_W + FRAC_W;
    localparam int CMP_W = (MAG_W > QW) ? MAG_W : QW;
    localparam logic [QW:0] HALF = (QW+1)'(1) << (FRAC_W - 1);

    logic              v1_reg, v2_reg, adv1, adv2;
    logic [QW-1:0]     m1_reg   [WHEELS];
    logic [WHEELS-1:0] neg1_reg;
    logic [OUT_W-1:0]  cmd2_reg [WHEELS];
    logic [QW-1:0]     limit_q;
    logic [CMP_W-1:0]  sel      [WHEELS];
    logic [QW:0]       sum      [WHEELS];
    logic [CMD_W:0]    rnd      [WHEELS];
    logic [CMD_W:0]    lim      [WHEELS];
    logic              zero_out;

    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;
    assign limit_q  = {cfg.max_command, {FRAC_W{1'b0}}};
    assign zero_out = (cfg.max_command == '0) || (cfg.units_per_rpm == '0);

    always_comb begin
        for (int w = 0; w < WHEELS; w++) begin
            sel[w] = in_bypass ? CMP_W'(in_mag[w]) : CMP_W'(in_quo[w]);
            sum[w] = (QW+1)'(m1_reg[w]) + HALF;
            rnd[w] = sum[w][QW:FRAC_W];
            lim[w] = (rnd[w] > (CMD_W+1)'(cfg.max_command)) ?
                     (CMD_W+1)'(cfg.max_command) : rnd[w];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && in_valid) begin
            for (int w = 0; w < WHEELS; w++) begin
                m1_reg[w] <= (sel[w] > CMP_W'(limit_q)) ? limit_q : sel[w][QW-1:0];
            end
            neg1_reg <= in_neg;
        end
        if (adv2 && v1_reg) begin
            for (int w = 0; w < WHEELS; w++) begin
                if (zero_out) begin
                    cmd2_reg[w] <= '0;
                end else if (neg1_reg[w]) begin
                    cmd2_reg[w] <= OUT_W'(~OUT_W'(lim[w]) + 1'b1);
                end else begin
                    cmd2_reg[w] <= OUT_W'(lim[w]);
                end
            end
        end
    end

    assign out_valid = v2_reg;
    assign out_cmd   = cmd2_reg;

endmodule

FILE: rtl/wheel_command_ratio_limiter.sv
// A beat passes the front stages, the divider (one quotient bit per stage) and rounding.
// Throughput: one wheel set per cycle while m_tready does not stall the pipeline.
// The output register holds a result while new beats keep flowing into empty stages.
// Reset (aresetn low, synchronous) empties the pipeline and loads register defaults.
// Top level: config registers, front stages, divider, rounding; uses wcrl_pkg.
// Instantiates wcrl_front, wcrl_divider and wcrl_round.
module wheel_command_ratio_limiter import wcrl_pkg::*; #(
    parameter int RPM_WIDTH          = RPM_WIDTH_DEF,
    parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // APB-style configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ADDR_W-1:0]                    paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    // input wheel speeds
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // rpm_front_left, rpm_front_right, rpm_rear_left, rpm_rear_right
    input  logic [((4*RPM_WIDTH+7)/8)*8-1:0]     s_tdata,
    // result commands
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // cmd_front_left, cmd_front_right, cmd_rear_left, cmd_rear_right
    output logic [63:0]                          m_tdata
);

    localparam int FRAC_W = RPM_FRACTION_BITS + GAIN_FRACTION_BITS;
    localparam int MAG_W  = RPM_WIDTH + GAIN_W;
    localparam int N_W    = MAG_W + CMD_W;
    localparam int QW     = CMD_W + FRAC_W;

    cfg_t       cfg_reg;
    reg_index_t wr_index;
    logic       wr_en;

    logic [RPM_WIDTH-1:0] rpm [WHEELS];

    logic              f_valid, f_ready, f_bypass;
    logic [N_W-1:0]    f_num [WHEELS];
    logic [MAG_W-1:0]  f_den;
    logic [MAG_W-1:0]  f_mag [WHEELS];
    logic [WHEELS-1:0] f_neg;

    logic              d_valid, d_ready, d_bypass;
    logic [QW-1:0]     d_quo [WHEELS];
    logic [MAG_W-1:0]  d_mag [WHEELS];
    logic [WHEELS-1:0] d_neg;

    logic [OUT_W-1:0]  cmd [WHEELS];

    // configuration: write on the access phase, read back the current value
    assign pready   = 1'b1;
    assign wr_index = reg_index_t'(paddr[3:2]);
    assign wr_en    = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_command     <= MAX_COMMAND_RST;
            cfg_reg.units_per_rpm   <= UNITS_PER_RPM_RST;
            cfg_reg.direction_flags <= DIRECTION_RST;
        end else if (wr_en) begin
            unique case (wr_index)
                REG_MAX_COMMAND:   cfg_reg.max_command     <= pwdata[CMD_W-1:0];
                REG_UNITS_PER_RPM: cfg_reg.units_per_rpm   <= pwdata[GAIN_W-1:0];
                REG_DIRECTION:     cfg_reg.direction_flags <= pwdata[WHEELS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (wr_index)
            REG_MAX_COMMAND:   prdata = 32'(cfg_reg.max_command);
            REG_UNITS_PER_RPM: prdata = 32'(cfg_reg.units_per_rpm);
            REG_DIRECTION:     prdata = 32'(cfg_reg.direction_flags);
            default:           prdata = '0;
        endcase
    end

    // unpack the input beat, front left in the lowest bits
    always_comb begin
        for (int w = 0; w < WHEELS; w++) begin
            rpm[w] = s_tdata[w*RPM_WIDTH +: RPM_WIDTH];
        end
    end

    // sign, gain, largest magnitude and scaling numerator
    wcrl_front #(
        .RPM_W  (RPM_WIDTH),
        .FRAC_W (FRAC_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_rpm     (rpm),
        .out_valid  (f_valid),
        .out_ready  (f_ready),
        .out_num    (f_num),
        .out_den    (f_den),
        .out_mag    (f_mag),
        .out_bypass (f_bypass),
        .out_neg    (f_neg)
    );

    // scaled magnitude = floor(mag * max_command * 2^FRAC_W / largest)
    wcrl_divider #(
        .MAG_W  (MAG_W),
        .FRAC_W (FRAC_W)
    ) u_divider (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (f_valid),
        .in_ready   (f_ready),
        .in_num     (f_num),
        .in_den     (f_den),
        .in_mag     (f_mag),
        .in_bypass  (f_bypass),
        .in_neg     (f_neg),
        .out_valid  (d_valid),
        .out_ready  (d_ready),
        .out_quo    (d_quo),
        .out_mag    (d_mag),
        .out_bypass (d_bypass),
        .out_neg    (d_neg)
    );

    // clamp, round half away from zero, restore the sign; last stage is the output register
    wcrl_round #(
        .MAG_W  (MAG_W),
        .FRAC_W (FRAC_W)
    ) u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .in_quo    (d_quo),
        .in_mag    (d_mag),
        .in_bypass (d_bypass),
        .in_neg    (d_neg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_cmd   (cmd)
    );

    assign m_tdata = {cmd[3], cmd[2], cmd[1], cmd[0]};

    // every command within plus or minus max_command
    logic [WHEELS-1:0]   in_range;
    logic signed [OUT_W:0] lim_s;
    logic signed [OUT_W:0] cmd_s [WHEELS];

    always_comb begin
        lim_s = $signed({2'b00, cfg_reg.max_command});
        for (int w = 0; w < WHEELS; w++) begin
            cmd_s[w]    = $signed({cmd[w][OUT_W-1], cmd[w]});
            in_range[w] = (cmd_s[w] <= lim_s) && (cmd_s[w] >= -lim_s);
        end
    end

    a_cmd_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (in_range == {WHEELS{1'b1}}))
        else $error("command beyond max_command");

    a_zero_gain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (cfg_reg.units_per_rpm == '0)) |-> (m_tdata == '0))
        else $error("zero gain gave a nonzero command");

    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("pipeline stalled with an empty output register");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule
